### hdl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property must never hold at any rising clock edge outside reset.
`define ASSERT_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) not (prop)) else $error(msg);

`endif

### hdl/i2cmbe_pkg.sv
// Package: payload types and codes of the I2C master byte engine.
`default_nettype none

package i2cmbe_pkg;

	// Command opcodes
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// Phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;
	localparam logic [1:0] PH_THREE = 2'd3;

	localparam logic [15:0] HALF_RESET = 16'd700;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_sample;
	} in_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_data;
	} out_t;

endpackage

`default_nettype wire

### hdl/i2c_master_byte_engine_top.sv
// Top level: I2C master byte engine with one tick per input transfer.
// Output: each result is registered into the main output register, or into the skid entry when the main one is held.
// Throughput: one input transfer per cycle while in_stall is low; a two-entry output stage absorbs stalls.
// Each transfer is one bus-timer tick; the state update is a single registered step.
// Reset: asynchronous, active low; engine idle, SCL and SDA released, period 700.
`default_nettype none

`include "assert_macros.svh"

module i2c_master_byte_engine_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire i2cmbe_pkg::in_t   in_data,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      i2cmbe_pkg::out_t  out_data
);
	import i2cmbe_pkg::*;

	// Engine state
	logic [15:0] half_q;
	logic [1:0]  phase_q, n_phase;
	logic [2:0]  cmd_q, n_cmd;
	logic [3:0]  bit_cnt_q, n_bit_cnt;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] delay_q, n_delay;
	logic        ack_flag_q, n_ack_flag;
	logic        ack_send_q, n_ack_send;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic [7:0]  last_read_q, n_last_read;
	logic        done;
	logic [15:0] load_val;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_w;
	logic [7:0]  shift_r;

	// Output stage: main register plus skid entry
	out_t out_q, skid_q, result;
	logic out_valid_q, skid_valid_q;
	logic in_fire, out_fire;

	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_fire  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Zero period counts as one tick
	assign load_val = (half_q == 16'd0) ? 16'd1 : half_q;
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign shift_w  = {shift_q[6:0], 1'b0};
	assign shift_r  = {shift_q[6:0], in_data.sda_sample};

	// One tick of the engine
	always_comb begin
		n_phase     = phase_q;
		n_cmd       = cmd_q;
		n_bit_cnt   = bit_cnt_q;
		n_shift     = shift_q;
		n_delay     = delay_q;
		n_ack_flag  = ack_flag_q;
		n_ack_send  = ack_send_q;
		n_scl       = scl_q;
		n_sda       = sda_q;
		n_last_read = last_read_q;
		done        = 1'b0;
		if (phase_q == PH_IDLE) begin
			case (in_data.opcode)
				OP_START: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				OP_STOP: begin
					n_sda = 1'b0;
				end
				OP_WRITE: begin
					n_shift   = in_data.write_data;
					n_bit_cnt = 4'd0;
					n_sda     = in_data.write_data[7];
				end
				OP_READ: begin
					n_ack_send = in_data.send_ack;
					n_shift    = 8'd0;
					n_bit_cnt  = 4'd0;
					n_sda      = 1'b1;
				end
				default: ;
			endcase
			if (in_data.opcode inside {OP_START, OP_STOP, OP_WRITE, OP_READ}) begin
				n_cmd   = in_data.opcode;
				n_phase = PH_ONE;
				n_delay = load_val;
			end
		end else if (delay_q > 16'd1) begin
			n_delay = delay_q - 16'd1;
		end else begin
			n_delay = 16'd0;
			if (cmd_q inside {OP_START, OP_STOP}) begin
				// Start / stop: three phases
				case (phase_q)
					PH_ONE: begin
						if (cmd_q == OP_START) n_sda = 1'b0;
						else n_scl = 1'b1;
						n_phase = PH_TWO;
						n_delay = load_val;
					end
					PH_TWO: begin
						if (cmd_q == OP_START) n_scl = 1'b0;
						else n_sda = 1'b1;
						n_phase = PH_THREE;
						n_delay = load_val;
					end
					default: done = 1'b1;
				endcase
			end else if (phase_q == PH_ONE) begin
				// SCL rises for the bit
				n_scl   = 1'b1;
				n_phase = PH_TWO;
				n_delay = load_val;
			end else begin
				// SCL falls; sample taken this tick
				n_scl = 1'b0;
				if (bit_cnt_q[3]) begin
					if (cmd_q == OP_WRITE) n_ack_flag = !in_data.sda_sample;
					else n_last_read = shift_q;
					done = 1'b1;
				end else begin
					n_bit_cnt = bit_inc;
					if (cmd_q == OP_WRITE) begin
						n_shift = shift_w;
						n_sda   = bit_inc[3] ? 1'b1 : shift_w[7];
					end else begin
						n_shift = shift_r;
						n_sda   = bit_inc[3] ? !ack_send_q : 1'b1;
					end
					n_phase = PH_ONE;
					n_delay = load_val;
				end
			end
			if (done) begin
				n_phase = PH_IDLE;
				n_cmd   = OP_NONE;
			end
		end
	end

	// Result of this tick
	always_comb begin
		result.scl_release = n_scl;
		result.sda_release = n_sda;
		result.busy_res    = (n_phase != PH_IDLE);
		result.done_res    = done;
		result.ack_seen    = n_ack_flag;
		result.read_data   = n_last_read;
	end

	// Engine registers, updated once per input transfer; the period register on cfg_we
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= HALF_RESET;
			phase_q     <= PH_IDLE;
			cmd_q       <= OP_NONE;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 8'd0;
			delay_q     <= 16'd0;
			ack_flag_q  <= 1'b0;
			ack_send_q  <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			last_read_q <= 8'd0;
		end else begin
			if (cfg_we) half_q <= cfg_wdata;
			if (in_fire) begin
				phase_q     <= n_phase;
				cmd_q       <= n_cmd;
				bit_cnt_q   <= n_bit_cnt;
				shift_q     <= n_shift;
				delay_q     <= n_delay;
				ack_flag_q  <= n_ack_flag;
				ack_send_q  <= n_ack_send;
				scl_q       <= n_scl;
				sda_q       <= n_sda;
				last_read_q <= n_last_read;
			end
		end
	end

	// Output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) out_q <= skid_q;
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) skid_q <= result;
			else out_q <= result;
		end
	end

	`ASSERT_CLK(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid entry without main entry")
	`ASSERT_CLK(a_delay_loaded, (phase_q != PH_IDLE) |-> (delay_q != 16'd0),
		"busy with empty delay")
	`ASSERT_NEVER(a_bit_range, bit_cnt_q > 4'd8, "bit count past ack slot")
	`ASSERT_NEVER(a_done_busy, out_valid_q && out_q.done_res && out_q.busy_res,
		"done reported while busy")
	`ASSERT_CLK(a_start_release,
		(in_fire && phase_q == PH_IDLE && in_data.opcode == OP_START) |=> (scl_q && sda_q),
		"start did not release both lines")

endmodule

`default_nettype wire
